### design/spcd_pkg.sv
// Types, constants and helper functions shared by the stereo pop/click detector.
package spcd_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int REG_BITS    = 24;
   localparam int OUT_CNT_BITS  = 32;
   localparam int OUT_PEAK_BITS = 24;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [CSR_IDX_BITS-1:0] REG_JUMP_LIMIT    = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SILENCE_LIMIT = 1'b1;

   localparam logic [REG_BITS-1:0] JUMP_LIMIT_RESET    = 24'd1258291;
   localparam logic [REG_BITS-1:0] SILENCE_LIMIT_RESET = 24'd8;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic KIND_FRAME  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [1:0] STATUS_EMPTY = 2'd0;
   localparam logic [1:0] STATUS_CLEAN = 2'd1;
   localparam logic [1:0] STATUS_POPS  = 2'd2;

   typedef struct packed {
      logic                          operation;
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
   } spcd_req_type;

   typedef struct packed {
      logic                     kind;
      logic                     pop_detected;
      logic [OUT_CNT_BITS-1:0]  window_frames;
      logic [OUT_CNT_BITS-1:0]  window_pops;
      logic [OUT_PEAK_BITS-1:0] peak_jump_left;
      logic [OUT_PEAK_BITS-1:0] peak_jump_right;
      logic [1:0]               window_status;
      logic [OUT_CNT_BITS-1:0]  all_pops;
      logic [OUT_CNT_BITS-1:0]  all_frames;
      logic [OUT_CNT_BITS-1:0]  silent_count;
   } spcd_rsp_type;

   typedef struct packed {
      logic                   now_silent;
      logic                   checked;
      logic                   pop;
      logic [SAMPLE_BITS-1:0] jump_left;
      logic [SAMPLE_BITS-1:0] jump_right;
   } spcd_eval_type;

   function automatic logic [SAMPLE_BITS-1:0] spcd_mag(input logic [SAMPLE_BITS-1:0] x);
      spcd_mag = x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
   endfunction

   // |a - b| on one extra bit; always fits SAMPLE_BITS unsigned
   function automatic logic [SAMPLE_BITS-1:0] spcd_jump(input logic [SAMPLE_BITS-1:0] a,
                                                        input logic [SAMPLE_BITS-1:0] b);
      logic [SAMPLE_BITS:0] diff;
      logic [SAMPLE_BITS:0] absd;
      diff = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
      absd = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;
      spcd_jump = absd[SAMPLE_BITS-1:0];
   endfunction

endpackage

### design/stereo_pop_click_detector.sv
// Stereo pop/click detector top level: input register, settings, result register.
// A word accepted into the input register is evaluated and written to the result register,
// which drives rsp_valid. One word per cycle while rsp_stall does not hold the result word;
// the path from the input register through the jump compare and counter update is combinational.
// Reset (synchronous) empties both registers, clears samples and counters and
// restores the jump threshold and silence_limit to their defaults.
module stereo_pop_click_detector #(
   parameter int COUNT_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  spcd_pkg::spcd_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output spcd_pkg::spcd_rsp_type             rsp_data,
   input  logic                               csr_wr_en,
   input  logic [spcd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [spcd_pkg::REG_BITS-1:0]      csr_wdata
);
   import spcd_pkg::*;

   logic [REG_BITS-1:0] jump_limit_ff;
   logic [REG_BITS-1:0] silence_limit_ff;
   logic                in_valid_ff,  in_valid_in;
   spcd_req_type        in_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   spcd_rsp_type        rsp_data_ff;
   logic                advance;
   logic                go;
   logic                req_take;
   spcd_eval_type       eval;
   spcd_rsp_type        result;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign go        = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)
         in_valid_in = 1'b1;
      else if (go)
         in_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (go)
         rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take)
         in_data_ff <= req_data;
      if (go)
         rsp_data_ff <= result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jump_limit_ff    <= JUMP_LIMIT_RESET;
         silence_limit_ff <= SILENCE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_JUMP_LIMIT:    jump_limit_ff    <= csr_wdata;
            REG_SILENCE_LIMIT: silence_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   spcd_frame_eval u_frame_eval (
      .clock         (clock),
      .reset         (reset),
      .go            (go),
      .item          (in_data_ff),
      .jump_limit    (jump_limit_ff),
      .silence_limit (silence_limit_ff),
      .eval          (eval)
   );

   spcd_window_stats #(
      .COUNT_BITS (COUNT_BITS)
   ) u_window_stats (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .operation (in_data_ff.operation),
      .eval      (eval),
      .result    (result)
   );

endmodule

### design/spcd_frame_eval.sv
// Silence test, per-channel jump and pop decision; holds the previous frame.
module spcd_frame_eval (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  spcd_pkg::spcd_req_type           item,
   input  logic [spcd_pkg::REG_BITS-1:0]    jump_limit,
   input  logic [spcd_pkg::REG_BITS-1:0]    silence_limit,
   output spcd_pkg::spcd_eval_type          eval
);
   import spcd_pkg::*;

   logic [SAMPLE_BITS-1:0] last_left_ff;
   logic [SAMPLE_BITS-1:0] last_right_ff;
   logic                   was_silent;

   always_comb begin
      was_silent = (spcd_mag(last_left_ff) < silence_limit) &&
                   (spcd_mag(last_right_ff) < silence_limit);
      eval.now_silent = (spcd_mag(item.left_sample) < silence_limit) &&
                        (spcd_mag(item.right_sample) < silence_limit);
      eval.checked    = !eval.now_silent && !was_silent;
      eval.jump_left  = spcd_jump(item.left_sample, last_left_ff);
      eval.jump_right = spcd_jump(item.right_sample, last_right_ff);
      eval.pop        = eval.checked &&
                        ((eval.jump_left > jump_limit) || (eval.jump_right > jump_limit));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_left_ff  <= '0;
         last_right_ff <= '0;
      end else if (go && item.operation == OP_FRAME) begin
         last_left_ff  <= item.left_sample;
         last_right_ff <= item.right_sample;
      end
   end

endmodule

### design/spcd_window_stats.sv
// Window peaks, saturating window and total counters, and result assembly.
module spcd_window_stats #(
   parameter int COUNT_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  logic                    operation,
   input  spcd_pkg::spcd_eval_type eval,
   output spcd_pkg::spcd_rsp_type  result
);
   import spcd_pkg::*;

   logic [SAMPLE_BITS-1:0] peak_left_ff,   peak_left_in;
   logic [SAMPLE_BITS-1:0] peak_right_ff,  peak_right_in;
   logic [COUNT_BITS-1:0]  win_pops_ff,    win_pops_in;
   logic [COUNT_BITS-1:0]  win_frames_ff,  win_frames_in;
   logic [COUNT_BITS-1:0]  tot_pops_ff,    tot_pops_in;
   logic [COUNT_BITS-1:0]  tot_frames_ff,  tot_frames_in;
   logic [COUNT_BITS-1:0]  tot_silent_ff,  tot_silent_in;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      sat_inc = (&c) ? c : c + 1'b1;
   endfunction

   function automatic logic [1:0] win_status(input logic [COUNT_BITS-1:0] frames,
                                             input logic [COUNT_BITS-1:0] pops);
      if (frames == '0)
         win_status = STATUS_EMPTY;
      else if (pops != '0)
         win_status = STATUS_POPS;
      else
         win_status = STATUS_CLEAN;
   endfunction

   always_comb begin
      peak_left_in  = peak_left_ff;
      peak_right_in = peak_right_ff;
      win_pops_in   = win_pops_ff;
      win_frames_in = win_frames_ff;
      tot_pops_in   = tot_pops_ff;
      tot_frames_in = tot_frames_ff;
      tot_silent_in = tot_silent_ff;
      result        = '0;

      unique case (operation)
         OP_TICK: begin
            result.kind            = KIND_REPORT;
            result.pop_detected    = 1'b0;
            result.window_frames   = OUT_CNT_BITS'(win_frames_ff);
            result.window_pops     = OUT_CNT_BITS'(win_pops_ff);
            result.peak_jump_left  = OUT_PEAK_BITS'(peak_left_ff);
            result.peak_jump_right = OUT_PEAK_BITS'(peak_right_ff);
            result.window_status   = win_status(win_frames_ff, win_pops_ff);
            peak_left_in  = '0;
            peak_right_in = '0;
            win_pops_in   = '0;
            win_frames_in = '0;
         end
         OP_FRAME: begin
            if (eval.checked && eval.jump_left > peak_left_ff)
               peak_left_in = eval.jump_left;
            if (eval.checked && eval.jump_right > peak_right_ff)
               peak_right_in = eval.jump_right;
            if (eval.pop) begin
               win_pops_in = sat_inc(win_pops_ff);
               tot_pops_in = sat_inc(tot_pops_ff);
            end
            if (eval.now_silent)
               tot_silent_in = sat_inc(tot_silent_ff);
            win_frames_in = sat_inc(win_frames_ff);
            tot_frames_in = sat_inc(tot_frames_ff);
            result.kind            = KIND_FRAME;
            result.pop_detected    = eval.pop;
            result.window_frames   = OUT_CNT_BITS'(win_frames_in);
            result.window_pops     = OUT_CNT_BITS'(win_pops_in);
            result.peak_jump_left  = OUT_PEAK_BITS'(peak_left_in);
            result.peak_jump_right = OUT_PEAK_BITS'(peak_right_in);
            result.window_status   = win_status(win_frames_in, win_pops_in);
         end
         default: begin
         end
      endcase

      result.all_pops     = OUT_CNT_BITS'(tot_pops_in);
      result.all_frames   = OUT_CNT_BITS'(tot_frames_in);
      result.silent_count = OUT_CNT_BITS'(tot_silent_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_left_ff  <= '0;
         peak_right_ff <= '0;
         win_pops_ff   <= '0;
         win_frames_ff <= '0;
         tot_pops_ff   <= '0;
         tot_frames_ff <= '0;
         tot_silent_ff <= '0;
      end else if (go) begin
         peak_left_ff  <= peak_left_in;
         peak_right_ff <= peak_right_in;
         win_pops_ff   <= win_pops_in;
         win_frames_ff <= win_frames_in;
         tot_pops_ff   <= tot_pops_in;
         tot_frames_ff <= tot_frames_in;
         tot_silent_ff <= tot_silent_in;
      end
   end

endmodule

### design/spcd_checker.sv
// Port-level checks for the stereo pop/click detector, bound to the top level.
module spcd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input spcd_pkg::spcd_rsp_type rsp_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall
);
   import spcd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_report_no_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_REPORT |-> !rsp_data.pop_detected)
      else $error("report word flags a pop");

   a_frame_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_FRAME |->
         (rsp_data.window_status == STATUS_CLEAN || rsp_data.window_status == STATUS_POPS))
      else $error("frame word shows an empty window");

   a_pop_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pop_detected |-> rsp_data.window_status == STATUS_POPS)
      else $error("pop without pops-seen status");

   // a fresh result word must come from a word taken at the request port
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result word without an accepted request");

endmodule

bind stereo_pop_click_detector spcd_checker u_spcd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

### sim/tb.sv
// Self-checking testbench for the stereo pop/click detector against a predictor.
module tb;
   import spcd_pkg::*;

   typedef enum logic [1:0] {ACT_WORD, ACT_CSR, ACT_DRAIN} step_kind_type;

   typedef struct packed {
      step_kind_type             kind;
      spcd_req_type              word;
      logic [CSR_IDX_BITS-1:0]   index;
      logic [REG_BITS-1:0]       value;
   } stim_step_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   spcd_req_type              req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   spcd_rsp_type              rsp_data;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]   csr_index = REG_JUMP_LIMIT;
   logic [REG_BITS-1:0]       csr_wdata = '0;

   stim_step_type             stim_plan[$];
   spcd_rsp_type              awaited_results[$];
   int                        mismatches = 0;

   // predictor state
   logic [REG_BITS-1:0]       pop_limit;
   logic [REG_BITS-1:0]       quiet_limit;
   logic [SAMPLE_BITS-1:0]    prev_left, prev_right;
   logic [SAMPLE_BITS-1:0]    peak_left, peak_right;
   logic [OUT_CNT_BITS-1:0]   win_pops, win_frames, tot_pops, tot_frames, tot_silent;

   int                        gap_left, settle, stall_left;
   logic                      src_burst = 1'b0;
   logic                      sink_burst = 1'b0;

   stereo_pop_click_detector u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic signed [SAMPLE_BITS:0] v);
      return v[SAMPLE_BITS] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
   endfunction

   function automatic logic is_quiet(input logic [SAMPLE_BITS-1:0] l,
                                     input logic [SAMPLE_BITS-1:0] r);
      return magnitude({l[SAMPLE_BITS-1], l}) < quiet_limit &&
             magnitude({r[SAMPLE_BITS-1], r}) < quiet_limit;
   endfunction

   function automatic logic [OUT_CNT_BITS-1:0] bump(input logic [OUT_CNT_BITS-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic spcd_rsp_type detect_pop(input spcd_req_type w);
      spcd_rsp_type           r;
      logic [SAMPLE_BITS-1:0] jl, jr;
      logic                   hit;
      logic                   quiet_now;
      r = '0;
      hit = 1'b0;
      if (w.operation == OP_FRAME) begin
         quiet_now = is_quiet(w.left_sample, w.right_sample);
         if (!quiet_now && !is_quiet(prev_left, prev_right)) begin
            jl = magnitude({w.left_sample[SAMPLE_BITS-1], w.left_sample} -
                           {prev_left[SAMPLE_BITS-1], prev_left});
            jr = magnitude({w.right_sample[SAMPLE_BITS-1], w.right_sample} -
                           {prev_right[SAMPLE_BITS-1], prev_right});
            if (jl > peak_left) peak_left = jl;
            if (jr > peak_right) peak_right = jr;
            if (jl > pop_limit || jr > pop_limit) begin
               hit = 1'b1;
               win_pops = bump(win_pops);
               tot_pops = bump(tot_pops);
            end
         end
         if (quiet_now) tot_silent = bump(tot_silent);
         prev_left = w.left_sample;
         prev_right = w.right_sample;
         win_frames = bump(win_frames);
         tot_frames = bump(tot_frames);
      end
      r.kind = (w.operation == OP_TICK) ? KIND_REPORT : KIND_FRAME;
      r.pop_detected = hit;
      r.window_frames = win_frames;
      r.window_pops = win_pops;
      r.peak_jump_left = peak_left;
      r.peak_jump_right = peak_right;
      if (win_frames == 0) r.window_status = STATUS_EMPTY;
      else if (win_pops != 0) r.window_status = STATUS_POPS;
      else r.window_status = STATUS_CLEAN;
      r.all_pops = tot_pops;
      r.all_frames = tot_frames;
      r.silent_count = tot_silent;
      if (w.operation == OP_TICK) begin
         peak_left = '0;
         peak_right = '0;
         win_pops = '0;
         win_frames = '0;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic add_word(input logic op, input int l, input int r);
      stim_step_type s;
      s = '0;
      s.kind = ACT_WORD;
      s.word.operation = op;
      s.word.left_sample = l[SAMPLE_BITS-1:0];
      s.word.right_sample = r[SAMPLE_BITS-1:0];
      stim_plan.push_back(s);
   endtask

   // settings only change once the detector has gone quiet
   task automatic add_setting(input logic [CSR_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] v);
      stim_step_type s;
      s = '0;
      s.kind = ACT_DRAIN;
      stim_plan.push_back(s);
      s.kind = ACT_CSR;
      s.index = idx;
      s.value = v;
      stim_plan.push_back(s);
   endtask

   // source side
   always @(posedge clock) begin
      stim_step_type           s;
      logic                    nxt_valid;
      spcd_req_type            nxt_data;
      logic                    nxt_wr;
      logic [CSR_IDX_BITS-1:0] nxt_index;
      logic [REG_BITS-1:0]     nxt_wdata;
      nxt_valid = req_valid;
      nxt_data = req_data;
      nxt_wr = 1'b0;
      nxt_index = csr_index;
      nxt_wdata = csr_wdata;
      if (reset) begin
         nxt_valid = 1'b0;
         gap_left = 0;
         settle = 0;
         pop_limit = JUMP_LIMIT_RESET;
         quiet_limit = SILENCE_LIMIT_RESET;
         prev_left = '0;
         prev_right = '0;
         peak_left = '0;
         peak_right = '0;
         win_pops = '0;
         win_frames = '0;
         tot_pops = '0;
         tot_frames = '0;
         tot_silent = '0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_results.push_back(detect_pop(req_data));
            nxt_valid = 1'b0;
            gap_left = src_burst ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 63) == 0) src_burst = !src_burst;
         end
         if (!nxt_valid && stim_plan.size() != 0) begin
            s = stim_plan[0];
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               case (s.kind)
                  ACT_WORD: begin
                     nxt_valid = 1'b1;
                     nxt_data = s.word;
                     void'(stim_plan.pop_front());
                  end
                  ACT_CSR: begin
                     nxt_wr = 1'b1;
                     nxt_index = s.index;
                     nxt_wdata = s.value;
                     if (s.index == REG_JUMP_LIMIT) pop_limit = s.value;
                     else if (s.index == REG_SILENCE_LIMIT) quiet_limit = s.value;
                     void'(stim_plan.pop_front());
                  end
                  default: begin
                     if (awaited_results.size() != 0) begin
                        settle = 0;
                     end else if (settle >= 3) begin
                        settle = 0;
                        void'(stim_plan.pop_front());
                     end else begin
                        settle++;
                     end
                  end
               endcase
            end
         end
      end
      req_valid <= nxt_valid;
      req_data <= nxt_data;
      csr_wr_en <= nxt_wr;
      csr_index <= nxt_index;
      csr_wdata <= nxt_wdata;
   end

   // result side
   always @(posedge clock) begin
      spcd_rsp_type want;
      logic         nxt_stall;
      nxt_stall = 1'b0;
      if (reset) begin
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: expected no result got %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_data.kind));
               check_field("pop_detected", 32'(want.pop_detected),
                           32'(rsp_data.pop_detected));
               check_field("window_frames", want.window_frames, rsp_data.window_frames);
               check_field("window_pops", want.window_pops, rsp_data.window_pops);
               check_field("peak_jump_left", 32'(want.peak_jump_left),
                           32'(rsp_data.peak_jump_left));
               check_field("peak_jump_right", 32'(want.peak_jump_right),
                           32'(rsp_data.peak_jump_right));
               check_field("window_status", 32'(want.window_status),
                           32'(rsp_data.window_status));
               check_field("all_pops", want.all_pops, rsp_data.all_pops);
               check_field("all_frames", want.all_frames, rsp_data.all_frames);
               check_field("silent_count", want.silent_count, rsp_data.silent_count);
            end
            stall_left = sink_burst ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 63) == 0) sink_burst = !sink_burst;
         end
         if (stall_left > 0) begin
            nxt_stall = 1'b1;
            stall_left--;
         end
      end
      rsp_stall <= nxt_stall;
   end

   initial begin
      int                  span, quiet, pick;
      int                  gen_l, gen_r;
      int                  extremes[3];
      logic [REG_BITS-1:0] thr, sil;
      extremes = '{8388607, -8388608, 0};
      gen_l = 0;
      gen_r = 0;

      // default settings
      add_word(OP_TICK, -1, 8388607);            // empty window
      add_word(OP_FRAME, 0, 0);                  // first frame, nothing to compare against
      add_word(OP_FRAME, 8388607, -8388608);
      add_word(OP_FRAME, -8388608, 8388607);     // full-scale jump on both channels
      add_word(OP_FRAME, 1, -1);
      add_word(OP_FRAME, 8, 0);                  // magnitude equal to limit is not silent
      add_word(OP_FRAME, 7, -8);
      add_word(OP_FRAME, 1258298, -8);           // jump equal to threshold
      add_word(OP_FRAME, 6, -8);                 // jump one above
      add_word(OP_TICK, 0, 0);
      add_word(OP_FRAME, 100000, -100000);
      add_word(OP_TICK, 8388607, -1);
      add_word(OP_TICK, 0, 0);

      add_setting(REG_JUMP_LIMIT, '0);
      add_setting(REG_SILENCE_LIMIT, '0);
      add_word(OP_FRAME, 0, 0);
      add_word(OP_FRAME, 0, 0);
      add_word(OP_FRAME, 1, 0);
      add_word(OP_TICK, 0, 0);

      // limit at full scale: only the most negative sample is loud
      add_setting(REG_JUMP_LIMIT, '1);
      add_setting(REG_SILENCE_LIMIT, 24'd8388608);
      add_word(OP_FRAME, -8388608, 8388607);
      add_word(OP_FRAME, 8388607, -8388608);
      add_word(OP_FRAME, 5, 5);
      add_word(OP_TICK, 0, 0);

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin
               thr = JUMP_LIMIT_RESET;
               sil = SILENCE_LIMIT_RESET;
            end
            1: begin
               thr = 24'($urandom_range(0, 4095));
               sil = 24'($urandom_range(0, 64));
            end
            2: begin
               thr = 24'($urandom);
               sil = 24'($urandom_range(0, 8388608));
            end
            default: begin
               thr = 24'($urandom_range(0, 1 << 20));
               sil = '0;
            end
         endcase
         add_setting(REG_JUMP_LIMIT, thr);
         add_setting(REG_SILENCE_LIMIT, sil);
         span = int'(thr) + int'(thr) / 4 + 16;
         quiet = (sil > 0) ? int'(sil) - 1 : 0;
         for (int n = 0; n < 216; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               add_word(OP_TICK, $urandom, $urandom);
            end else begin
               if (pick < 70) begin
                  gen_l += int'($urandom_range(0, 2 * span)) - span;
                  gen_r += int'($urandom_range(0, 2 * span)) - span;
               end else if (pick < 80) begin
                  gen_l = int'($urandom_range(0, 2 * quiet)) - quiet;
                  gen_r = int'($urandom_range(0, 2 * quiet)) - quiet;
               end else if (pick < 92) begin
                  gen_l = $urandom;
                  gen_r = $urandom;
               end else begin
                  gen_l = extremes[$urandom_range(0, 2)];
                  gen_r = extremes[$urandom_range(0, 2)];
               end
               gen_l = (gen_l <<< 8) >>> 8;
               gen_r = (gen_r <<< 8) >>> 8;
               add_word(OP_FRAME, gen_l, gen_r);
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (stim_plan.size() != 0 || awaited_results.size() != 0 || req_valid)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("PASS stereo_pop_click_detector");
      else
         $display("FAIL stereo_pop_click_detector");
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL stereo_pop_click_detector");
      $finish;
   end

endmodule
